>>> hw/rtl/udpd_pkg.sv
// Shared types, codes and constants of the UDP receive deframer.
package udpd_pkg;

  localparam int BUF_BYTES = 128;
  localparam int LEN_BITS  = 16;
  localparam int SPACE_W   = $clog2(BUF_BYTES + 1);
  localparam int REM_W     = LEN_BITS + 1;
  localparam int NV_W      = LEN_BITS + 4;
  localparam int HDR_LEN   = 8;
  localparam int MATCH_W   = $clog2(HDR_LEN);
  localparam int TMO_W     = 16;
  localparam int PLEN_W    = 16;

  localparam logic [NV_W-1:0] MAX_LEN = NV_W'((64'd1 << LEN_BITS) - 64'd1);

  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_HUNT    = 3'd1;
  localparam logic [2:0] PH_COMMA   = 3'd2;
  localparam logic [2:0] PH_ADDR    = 3'd3;
  localparam logic [2:0] PH_PORT    = 3'd4;
  localparam logic [2:0] PH_LEN     = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_BADLEN  = 3'd7;

  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd1;
  localparam logic [2:0] ST_PARSE   = 3'd2;
  localparam logic [2:0] ST_ZERO    = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_TIMEOUT = 3'd5;

  localparam logic REG_HDR_TMO = 1'b0;
  localparam logic REG_PAY_TMO = 1'b1;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic              data_valid;
    logic [7:0]        data_byte;
    logic [2:0]        status;
    logic [PLEN_W-1:0] payload_length;
  } res_t;

  typedef struct packed {
    logic [TMO_W-1:0] header_timeout;
    logic [TMO_W-1:0] payload_timeout;
  } cfg_t;

  function automatic logic [7:0] hdr_char(input logic [MATCH_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h2B;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h44;
      3'd4:    c = 8'h55;
      3'd5:    c = 8'h53;
      3'd6:    c = 8'h3A;
      default: c = 8'h32;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/udp_receive_deframer.sv
// Top level of the UDP receive deframer: word register, parser and result register.
// Takes one word (received byte, millisecond tick or start) per clock while the
// result side is ready and returns one result per word through the input and result
// registers. The parser state updates as a word moves from the input register to the
// result register, so back-to-back words run at one per cycle; a stalled result holds
// the result register and one further word waits in the input register. Timeout
// registers must be written by the user through the cfg port only while the block is idle (not enforced).
module udp_receive_deframer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_cmd,
  input  logic [7:0]                   in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_data_valid,
  output logic [7:0]                   out_data_byte,
  output logic [2:0]                   out_status,
  output logic [udpd_pkg::PLEN_W-1:0]  out_payload_length,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [udpd_pkg::TMO_W-1:0]   cfg_data
);

  logic            s1_valid_r, s1_valid_nxt;
  udpd_pkg::item_t s1_item_r;
  logic            out_valid_r, out_valid_nxt;
  udpd_pkg::res_t  out_res_r;
  udpd_pkg::res_t  core_res;
  udpd_pkg::cfg_t  cfg_r;
  logic            adv;
  logic            in_acc;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_acc   = in_valid && in_ready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  udpd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_item_r <= '{cmd: in_cmd, rx_byte: in_rx_byte};
    if (adv) out_res_r <= core_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_timeout  <= udpd_pkg::TMO_W'(5000);
      cfg_r.payload_timeout <= udpd_pkg::TMO_W'(1000);
    end else if (cfg_we) begin
      if (cfg_index == udpd_pkg::REG_HDR_TMO) cfg_r.header_timeout <= cfg_data;
      if (cfg_index == udpd_pkg::REG_PAY_TMO) cfg_r.payload_timeout <= cfg_data;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data_valid     = out_res_r.data_valid;
  assign out_data_byte      = out_res_r.data_byte;
  assign out_status         = out_res_r.status;
  assign out_payload_length = out_res_r.payload_length;

endmodule

>>> hw/rtl/udpd_core.sv
// Parser state and per-word next-state and result logic.
module udpd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  udpd_pkg::item_t item,
  input  udpd_pkg::cfg_t  cfg,
  output udpd_pkg::res_t  res
);

  logic [2:0]                    phase_r, phase_nxt;
  logic [udpd_pkg::MATCH_W-1:0]  match_r, match_nxt;
  logic [udpd_pkg::SPACE_W-1:0]  space_r, space_nxt;
  logic [udpd_pkg::REM_W-1:0]    rem_r, rem_nxt;
  logic [udpd_pkg::TMO_W-1:0]    elapsed_r, elapsed_nxt;
  logic [udpd_pkg::TMO_W-1:0]    limit_r, limit_nxt;

  logic [udpd_pkg::TMO_W-1:0]    el_inc;
  logic [udpd_pkg::LEN_BITS-1:0] rem_len;
  logic [udpd_pkg::NV_W-1:0]     len_nv;
  logic [udpd_pkg::REM_W-1:0]    rem_dec;
  logic                          is_digit;
  logic [7:0]                    b;

  localparam logic [udpd_pkg::SPACE_W-1:0] SPACE_FULL =
    udpd_pkg::SPACE_W'(udpd_pkg::BUF_BYTES);

  assign b        = item.rx_byte;
  assign rem_len  = rem_r[udpd_pkg::LEN_BITS-1:0];
  assign is_digit = (b >= udpd_pkg::CH_ZERO) && (b <= udpd_pkg::CH_NINE);
  assign len_nv   = {1'b0, rem_len, 3'b000} + {3'b000, rem_len, 1'b0}
                  + udpd_pkg::NV_W'(b - udpd_pkg::CH_ZERO);
  assign rem_dec  = rem_r - udpd_pkg::REM_W'(1);
  assign el_inc   = (elapsed_r != {udpd_pkg::TMO_W{1'b1}}) ?
                    elapsed_r + udpd_pkg::TMO_W'(1) : elapsed_r;

  always_comb begin
    phase_nxt   = phase_r;
    match_nxt   = match_r;
    space_nxt   = space_r;
    rem_nxt     = rem_r;
    elapsed_nxt = elapsed_r;
    limit_nxt   = limit_r;
    res         = '0;
    unique case (item.cmd)
      udpd_pkg::CMD_START: begin
        phase_nxt   = udpd_pkg::PH_HUNT;
        match_nxt   = '0;
        space_nxt   = SPACE_FULL;
        rem_nxt     = '0;
        elapsed_nxt = '0;
        limit_nxt   = cfg.header_timeout;
      end
      udpd_pkg::CMD_TICK: begin
        if (phase_r != udpd_pkg::PH_IDLE) begin
          elapsed_nxt = el_inc;
          if ((limit_r != '0) && (el_inc >= limit_r)) begin
            res.status = udpd_pkg::ST_TIMEOUT;
            phase_nxt  = udpd_pkg::PH_IDLE;
            match_nxt  = '0;
          end
        end
      end
      udpd_pkg::CMD_BYTE: begin
        if (phase_r != udpd_pkg::PH_IDLE) begin
          if ((phase_r != udpd_pkg::PH_PAYLOAD) && (space_r == '0)) begin
            res.status = udpd_pkg::ST_FULL;
            phase_nxt  = udpd_pkg::PH_IDLE;
            match_nxt  = '0;
          end else if (b == udpd_pkg::CH_CR) begin
            if (rem_r != '0) rem_nxt = rem_dec;
          end else begin
            unique case (phase_r)
              udpd_pkg::PH_HUNT: begin
                if (b == udpd_pkg::hdr_char(match_r)) begin
                  match_nxt = match_r + udpd_pkg::MATCH_W'(1);
                  if (match_r == udpd_pkg::MATCH_W'(udpd_pkg::HDR_LEN - 1)) begin
                    match_nxt = '0;
                    phase_nxt = udpd_pkg::PH_COMMA;
                    space_nxt = SPACE_FULL;
                  end
                end else begin
                  match_nxt = (b == udpd_pkg::hdr_char('0)) ?
                              udpd_pkg::MATCH_W'(1) : '0;
                  space_nxt = space_r - udpd_pkg::SPACE_W'(1);
                end
              end
              udpd_pkg::PH_COMMA: begin
                if (b == udpd_pkg::CH_COMMA) begin
                  phase_nxt = udpd_pkg::PH_ADDR;
                  space_nxt = SPACE_FULL;
                end else begin
                  phase_nxt = udpd_pkg::PH_BADLEN;
                end
              end
              udpd_pkg::PH_ADDR, udpd_pkg::PH_PORT: begin
                if (b == udpd_pkg::CH_COMMA)
                  phase_nxt = (phase_r == udpd_pkg::PH_ADDR) ?
                              udpd_pkg::PH_PORT : udpd_pkg::PH_LEN;
                space_nxt = space_r - udpd_pkg::SPACE_W'(1);
              end
              udpd_pkg::PH_LEN: begin
                if (is_digit) begin
                  if (len_nv > udpd_pkg::MAX_LEN) phase_nxt = udpd_pkg::PH_BADLEN;
                  else rem_nxt = udpd_pkg::REM_W'(len_nv);
                  space_nxt = space_r - udpd_pkg::SPACE_W'(1);
                end else if (b == udpd_pkg::CH_COMMA) begin
                  if (rem_r == '0) begin
                    res.status = udpd_pkg::ST_ZERO;
                    phase_nxt  = udpd_pkg::PH_IDLE;
                    match_nxt  = '0;
                  end else begin
                    res.payload_length = udpd_pkg::PLEN_W'(rem_len);
                    rem_nxt     = rem_r + udpd_pkg::REM_W'(2);
                    phase_nxt   = udpd_pkg::PH_PAYLOAD;
                    elapsed_nxt = '0;
                    limit_nxt   = cfg.payload_timeout;
                  end
                end else begin
                  phase_nxt = udpd_pkg::PH_BADLEN;
                  space_nxt = space_r - udpd_pkg::SPACE_W'(1);
                end
              end
              udpd_pkg::PH_BADLEN: begin
                if (b == udpd_pkg::CH_LF) begin
                  res.status = udpd_pkg::ST_PARSE;
                  phase_nxt  = udpd_pkg::PH_IDLE;
                  match_nxt  = '0;
                end else begin
                  space_nxt = space_r - udpd_pkg::SPACE_W'(1);
                end
              end
              udpd_pkg::PH_PAYLOAD: begin
                if (rem_r == '0) begin
                  res.status = udpd_pkg::ST_FULL;
                  phase_nxt  = udpd_pkg::PH_IDLE;
                  match_nxt  = '0;
                end else begin
                  rem_nxt = rem_dec;
                  if (rem_dec == '0) begin
                    res.status = udpd_pkg::ST_OK;
                    phase_nxt  = udpd_pkg::PH_IDLE;
                    match_nxt  = '0;
                  end else begin
                    res.data_valid = 1'b1;
                    res.data_byte  = b;
                  end
                end
              end
              udpd_pkg::PH_IDLE: begin
                phase_nxt = udpd_pkg::PH_IDLE;
                match_nxt = '0;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= udpd_pkg::PH_IDLE;
      match_r   <= '0;
      space_r   <= SPACE_FULL;
      rem_r     <= '0;
      elapsed_r <= '0;
      limit_r   <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      match_r   <= match_nxt;
      space_r   <= space_nxt;
      rem_r     <= rem_nxt;
      elapsed_r <= elapsed_nxt;
      limit_r   <= limit_nxt;
    end
  end

endmodule

>>> hw/rtl/udpd_checker.sv
// Port-level checker for the UDP receive deframer and its bind.
module udpd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_data_valid,
  input logic [7:0]                  out_data_byte,
  input logic [2:0]                  out_status,
  input logic [udpd_pkg::PLEN_W-1:0] out_payload_length
);

  a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_valid |-> out_status == udpd_pkg::ST_BUSY)
    else $error("payload word carries a final status");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data_valid |-> out_data_byte == 8'd0)
    else $error("data byte set without data valid");

  a_len_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_payload_length != '0) |->
      !out_data_valid && (out_status == udpd_pkg::ST_BUSY))
    else $error("length given together with data or status");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte)
      && $stable(out_status) && $stable(out_payload_length))
    else $error("stalled result changed");

endmodule

bind udp_receive_deframer udpd_checker u_udpd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_data_valid     (out_data_valid),
  .out_data_byte      (out_data_byte),
  .out_status         (out_status),
  .out_payload_length (out_payload_length)
);

>>> tb/udp_receive_deframer_tb.sv
// Self-checking testbench of the UDP receive deframer: random framed streams against a parser model.
`timescale 1ns / 100ps

module udp_receive_deframer_tb;

  localparam logic [63:0] HDR_TEXT   = "+TRDUS:2";
  localparam int          QUIET_MAX  = 2000;
  localparam int          RAND_WORDS = 1100;

  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic                          in_ready;
  logic [1:0]                    in_cmd         = udpd_pkg::CMD_BYTE;
  logic [7:0]                    in_rx_byte     = 8'h00;
  logic                          out_valid;
  logic                          out_ready      = 1'b0;
  logic                          out_data_valid;
  logic [7:0]                    out_data_byte;
  logic [2:0]                    out_status;
  logic [udpd_pkg::PLEN_W-1:0]   out_payload_length;
  logic                          cfg_we         = 1'b0;
  logic                          cfg_index      = udpd_pkg::REG_HDR_TMO;
  logic [udpd_pkg::TMO_W-1:0]    cfg_data       = '0;

  // parser model state and its copy of the timeout registers
  logic [2:0]                    ph         = udpd_pkg::PH_IDLE;
  logic [udpd_pkg::MATCH_W:0]    match_cnt  = '0;
  logic [udpd_pkg::SPACE_W-1:0]  space_left = udpd_pkg::SPACE_W'(udpd_pkg::BUF_BYTES);
  logic [udpd_pkg::REM_W-1:0]    remaining  = '0;
  logic [udpd_pkg::TMO_W-1:0]    elapsed    = '0;
  logic [udpd_pkg::TMO_W-1:0]    act_limit  = '0;
  logic [udpd_pkg::TMO_W-1:0]    hdr_tmo    = udpd_pkg::TMO_W'(5000);
  logic [udpd_pkg::TMO_W-1:0]    pay_tmo    = udpd_pkg::TMO_W'(1000);

  udpd_pkg::item_t pending_words[$];
  udpd_pkg::res_t  awaited_results[$];
  int    words_queued = 0;
  int    mismatches   = 0;
  int    quiet_cycles = 0;
  int    idle_pct     = 31;
  int    stall_pct    = 31;
  int    tick_pct     = 0;

  udp_receive_deframer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data_valid     (out_data_valid),
    .out_data_byte      (out_data_byte),
    .out_status         (out_status),
    .out_payload_length (out_payload_length),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic advance_parser(input udpd_pkg::item_t w, output udpd_pkg::res_t r);
    logic [udpd_pkg::NV_W-1:0] grown;
    logic [7:0]                want_ch;
    logic [2:0]                verdict;
    verdict = udpd_pkg::ST_BUSY;
    r = '0;
    want_ch = HDR_TEXT[8*(udpd_pkg::HDR_LEN-1-int'(match_cnt[udpd_pkg::MATCH_W-1:0])) +: 8];
    if (w.cmd == udpd_pkg::CMD_START) begin
      ph = udpd_pkg::PH_HUNT;
      match_cnt = '0;
      space_left = udpd_pkg::SPACE_W'(udpd_pkg::BUF_BYTES);
      remaining = '0;
      elapsed = '0;
      act_limit = hdr_tmo;
    end else if (w.cmd == udpd_pkg::CMD_TICK && ph != udpd_pkg::PH_IDLE) begin
      if (elapsed != {udpd_pkg::TMO_W{1'b1}}) elapsed++;
      if (act_limit != 0 && elapsed >= act_limit) verdict = udpd_pkg::ST_TIMEOUT;
    end else if (w.cmd == udpd_pkg::CMD_BYTE && ph != udpd_pkg::PH_IDLE) begin
      if (ph != udpd_pkg::PH_PAYLOAD && space_left == 0) begin
        verdict = udpd_pkg::ST_FULL;
      end else if (w.rx_byte == udpd_pkg::CH_CR) begin
        if (remaining != 0) remaining--;
      end else begin
        case (ph)
          udpd_pkg::PH_HUNT: begin
            if (w.rx_byte == want_ch) begin
              match_cnt++;
              if (match_cnt >= udpd_pkg::HDR_LEN) begin
                match_cnt = '0;
                ph = udpd_pkg::PH_COMMA;
                space_left = udpd_pkg::SPACE_W'(udpd_pkg::BUF_BYTES);
              end
            end else begin
              match_cnt = (w.rx_byte == HDR_TEXT[63:56]) ?
                          {{udpd_pkg::MATCH_W{1'b0}}, 1'b1} : '0;
              space_left--;
            end
          end
          udpd_pkg::PH_COMMA: begin
            if (w.rx_byte == udpd_pkg::CH_COMMA) begin
              ph = udpd_pkg::PH_ADDR;
              space_left = udpd_pkg::SPACE_W'(udpd_pkg::BUF_BYTES);
            end else begin
              ph = udpd_pkg::PH_BADLEN;
            end
          end
          udpd_pkg::PH_ADDR, udpd_pkg::PH_PORT: begin
            if (w.rx_byte == udpd_pkg::CH_COMMA)
              ph = (ph == udpd_pkg::PH_ADDR) ? udpd_pkg::PH_PORT : udpd_pkg::PH_LEN;
            space_left--;
          end
          udpd_pkg::PH_LEN: begin
            if (w.rx_byte >= udpd_pkg::CH_ZERO && w.rx_byte <= udpd_pkg::CH_NINE) begin
              grown = udpd_pkg::NV_W'(remaining) * udpd_pkg::NV_W'(10)
                    + udpd_pkg::NV_W'(w.rx_byte - udpd_pkg::CH_ZERO);
              if (grown > udpd_pkg::MAX_LEN) ph = udpd_pkg::PH_BADLEN;
              else remaining = udpd_pkg::REM_W'(grown);
              space_left--;
            end else if (w.rx_byte == udpd_pkg::CH_COMMA) begin
              if (remaining == 0) begin
                verdict = udpd_pkg::ST_ZERO;
              end else begin
                r.payload_length = udpd_pkg::PLEN_W'(remaining);
                remaining = remaining + udpd_pkg::REM_W'(2);
                ph = udpd_pkg::PH_PAYLOAD;
                elapsed = '0;
                act_limit = pay_tmo;
              end
            end else begin
              ph = udpd_pkg::PH_BADLEN;
              space_left--;
            end
          end
          udpd_pkg::PH_BADLEN: begin
            if (w.rx_byte == udpd_pkg::CH_LF) verdict = udpd_pkg::ST_PARSE;
            else space_left--;
          end
          udpd_pkg::PH_PAYLOAD: begin
            if (remaining == 0) begin
              verdict = udpd_pkg::ST_FULL;
            end else begin
              remaining--;
              if (remaining == 0) begin
                verdict = udpd_pkg::ST_OK;
              end else begin
                r.data_valid = 1'b1;
                r.data_byte = w.rx_byte;
              end
            end
          end
          default: begin
            ph = udpd_pkg::PH_IDLE;
            match_cnt = '0;
          end
        endcase
      end
    end
    if (verdict != udpd_pkg::ST_BUSY) begin
      r.status = verdict;
      ph = udpd_pkg::PH_IDLE;
      match_cnt = '0;
    end
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $time);
  endtask

  always @(posedge clk) begin : drive_words
    udpd_pkg::item_t w;
    udpd_pkg::res_t  r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        w.cmd = in_cmd;
        w.rx_byte = in_rx_byte;
        advance_parser(w, r);
        awaited_results.push_back(r);
      end
      if ((!in_valid || in_ready) && pending_words.size() != 0
          && $urandom_range(99) >= idle_pct) begin
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_cmd <= w.cmd;
        in_rx_byte <= w.rx_byte;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_results
    udpd_pkg::res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("unexpected result", out_status, 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data_valid !== want.data_valid)
            flag_mismatch("data_valid", out_data_valid, want.data_valid);
          if (out_data_byte !== want.data_byte)
            flag_mismatch("data_byte", out_data_byte, want.data_byte);
          if (out_status !== want.status)
            flag_mismatch("status", out_status, want.status);
          if (out_payload_length !== want.payload_length)
            flag_mismatch("payload_length", out_payload_length, want.payload_length);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("** udp_receive_deframer: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_word(input logic [1:0] cmd, input logic [7:0] b);
    udpd_pkg::item_t w;
    w.cmd = cmd;
    w.rx_byte = b;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    if ($urandom_range(99) < tick_pct) queue_word(udpd_pkg::CMD_TICK, 8'($urandom));
    queue_word(udpd_pkg::CMD_BYTE, b);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  function automatic logic [7:0] field_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == udpd_pkg::CH_COMMA) b = ".";
    return b;
  endfunction

  task automatic queue_junk_line();
    logic [7:0] b;
    repeat ($urandom_range(0, 6)) begin
      b = 8'($urandom);
      queue_byte((b == udpd_pkg::CH_LF) ? 8'h00 : b);
    end
    queue_byte(udpd_pkg::CH_LF);
  endtask

  // one reception: mostly well formed, otherwise broken in one of several ways
  task automatic queue_frame();
    int    kind;
    int    len;
    string len_txt;
    kind = $urandom_range(99);
    len = ($urandom_range(19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
    queue_word(udpd_pkg::CMD_START, 8'($urandom));
    if (kind >= 95) begin
      repeat ($urandom_range(5, 20)) queue_word(2'($urandom_range(3)), 8'($urandom));
      return;
    end
    if ($urandom_range(3) == 0) queue_text("+TR");
    if (kind >= 78 && kind < 82) begin
      if ($urandom_range(1)) queue_text("+TRDUS:2,");
      repeat ($urandom_range(129, 140)) queue_byte(8'($urandom));
      return;
    end
    queue_text("+TRDUS:2");
    if (kind >= 74 && kind < 78) begin
      queue_byte(field_byte());
      queue_junk_line();
      return;
    end
    queue_byte(udpd_pkg::CH_COMMA);
    repeat ($urandom_range(0, 15)) queue_byte(field_byte());
    queue_byte(udpd_pkg::CH_COMMA);
    queue_text($sformatf("%0d", $urandom_range(65535)));
    queue_byte(udpd_pkg::CH_COMMA);
    if (kind >= 60 && kind < 65)
      len_txt = $urandom_range(1) ? "0" : "000";
    else if (kind >= 65 && kind < 70)
      len_txt = {$sformatf("%0d", len), "x"};
    else if (kind >= 70 && kind < 74)
      len_txt = $urandom_range(1) ? "65536" : $sformatf("%0d", $urandom_range(65536, 999999));
    else
      len_txt = $sformatf("%0d", len);
    queue_text(len_txt);
    if (kind >= 65 && kind < 74) begin
      queue_junk_line();
      return;
    end
    if (kind >= 82 && kind < 86) queue_byte(udpd_pkg::CH_CR);
    queue_byte(udpd_pkg::CH_COMMA);
    if (kind >= 60 && kind < 65) return;
    if (kind >= 82 && kind < 86) begin
      repeat (len + 2 + $urandom_range(2)) queue_byte(udpd_pkg::CH_CR);
      queue_byte(8'($urandom));
      return;
    end
    if (kind >= 86) begin
      repeat ($urandom_range(0, len)) queue_byte(8'($urandom));
      if (kind < 90) repeat ($urandom_range(1, 40)) queue_word(udpd_pkg::CMD_TICK, 8'($urandom));
      return;
    end
    repeat (len) queue_byte(8'($urandom));
    queue_byte(udpd_pkg::CH_CR);
    queue_byte(udpd_pkg::CH_LF);
    if ($urandom_range(7) == 0) queue_byte(8'($urandom));
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_timeouts(input logic [udpd_pkg::TMO_W-1:0] h,
                              input logic [udpd_pkg::TMO_W-1:0] p);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= udpd_pkg::REG_HDR_TMO;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= udpd_pkg::REG_PAY_TMO;
    cfg_data <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    hdr_tmo = h;
    pay_tmo = p;
  endtask

  task automatic run_phase(input logic [udpd_pkg::TMO_W-1:0] h,
                           input logic [udpd_pkg::TMO_W-1:0] p,
                           input int idle, input int stall, input int ticks, input bit flood);
    int stop_at;
    drain();
    set_timeouts(h, p);
    idle_pct = idle;
    stall_pct = stall;
    tick_pct = ticks;
    stop_at = words_queued + RAND_WORDS / 6;
    if (flood) begin
      queue_word(udpd_pkg::CMD_START, 8'h00);
      repeat (int'(h) + 5) queue_word(udpd_pkg::CMD_TICK, 8'($urandom));
    end
    while (words_queued < stop_at) queue_frame();
  endtask

  initial begin
    queue_word(udpd_pkg::CMD_BYTE, 8'hFF);
    queue_word(udpd_pkg::CMD_TICK, 8'h00);
    queue_word(udpd_pkg::CMD_UNUSED, 8'hAA);
    queue_word(udpd_pkg::CMD_START, 8'h55);
    queue_text("++TRDUS:2,,,2,");
    queue_word(udpd_pkg::CMD_BYTE, 8'h00);
    queue_word(udpd_pkg::CMD_BYTE, 8'hFF);
    queue_word(udpd_pkg::CMD_BYTE, udpd_pkg::CH_CR);
    queue_word(udpd_pkg::CMD_BYTE, udpd_pkg::CH_LF);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    run_phase(udpd_pkg::TMO_W'(20), udpd_pkg::TMO_W'(12), 31, 31, 15, 1'b0);
    run_phase('0, '0, 31, 31, 20, 1'b0);
    run_phase(udpd_pkg::TMO_W'(100), {udpd_pkg::TMO_W{1'b1}}, 31, 31, 5, 1'b1);
    run_phase(udpd_pkg::TMO_W'(1), udpd_pkg::TMO_W'(1), 31, 31, 2, 1'b0);
    run_phase(udpd_pkg::TMO_W'(30), udpd_pkg::TMO_W'(8), 0, 0, 10, 1'b0);
    run_phase(udpd_pkg::TMO_W'(5000), udpd_pkg::TMO_W'(1000), 31, 31, 5, 1'b0);
    drain();

    if (mismatches == 0) begin
      $display("** udp_receive_deframer: PASSED **");
    end else begin
      $display("** udp_receive_deframer: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/udpd_pkg.sv
hw/rtl/udpd_core.sv
hw/rtl/udp_receive_deframer.sv
hw/rtl/udpd_checker.sv
tb/udp_receive_deframer_tb.sv
